### src/smcw_pkg.sv
// Shared types, constants and the exponent table for the softmax child weighting core.
// Used by every module of the block; depends on nothing.
package smcw_pkg;

  localparam int MaxChildren = 64;
  localparam int IdxW        = $clog2(MaxChildren);
  localparam int CntW        = IdxW + 1;
  localparam int ExpDepth    = 256;
  localparam int ExpAw       = $clog2(ExpDepth);
  localparam int RawW        = 17;
  localparam int PsW         = 24;
  localparam int SumW        = RawW + IdxW;
  localparam int NumW        = RawW + PsW + 1;
  localparam int QuoW        = PsW;
  localparam int DivCntW     = $clog2(QuoW);
  localparam int AccW        = 48;
  localparam int ExpTerms    = 24;

  localparam logic [16:0]        Log2eQ16   = 17'd94548;
  localparam longint unsigned    Ln2Q30     = 64'd744261118;
  localparam longint unsigned    OneQ30     = 64'd1073741824;
  localparam longint unsigned    Two35      = 64'd34359738368;
  localparam logic [7:0]         SharpReset = 8'd35;
  localparam logic signed [15:0] BestReset  = -16'sd16384;
  localparam logic [2:0]         AddrSharp  = 3'd0;

  typedef longint unsigned recip_t [ExpTerms + 1];

  // ceil(2^35 / n): exact floor division by n of any value below 2^30
  localparam recip_t RecipQ35 = '{
    64'd0,
    Two35,
    (Two35 + 64'd1) / 64'd2,
    (Two35 + 64'd2) / 64'd3,
    (Two35 + 64'd3) / 64'd4,
    (Two35 + 64'd4) / 64'd5,
    (Two35 + 64'd5) / 64'd6,
    (Two35 + 64'd6) / 64'd7,
    (Two35 + 64'd7) / 64'd8,
    (Two35 + 64'd8) / 64'd9,
    (Two35 + 64'd9) / 64'd10,
    (Two35 + 64'd10) / 64'd11,
    (Two35 + 64'd11) / 64'd12,
    (Two35 + 64'd12) / 64'd13,
    (Two35 + 64'd13) / 64'd14,
    (Two35 + 64'd14) / 64'd15,
    (Two35 + 64'd15) / 64'd16,
    (Two35 + 64'd16) / 64'd17,
    (Two35 + 64'd17) / 64'd18,
    (Two35 + 64'd18) / 64'd19,
    (Two35 + 64'd19) / 64'd20,
    (Two35 + 64'd20) / 64'd21,
    (Two35 + 64'd21) / 64'd22,
    (Two35 + 64'd22) / 64'd23,
    (Two35 + 64'd23) / 64'd24
  };

  typedef struct packed {
    logic [15:0]        child_prior;
    logic signed [15:0] child_q;
    logic signed [15:0] own_value;
    logic               last_child;
  } item_t;

  typedef struct packed {
    logic [5:0]         child_index;
    logic [15:0]        child_weight;
    logic signed [15:0] node_value;
    logic               last_result;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic load;
    logic init;
    logic p1_rd;
    logic m1;
    logic m2;
    logic ex;
    logic p2_rd;
    logic p2_mul;
    logic div_go;
    logic acc;
    logic nv;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_done;
  } stat_t;

  typedef logic [RawW-1:0] exp_table_t [ExpDepth];

  // exp(-s), s in Q30 below 1.0, rounded to Q16
  function automatic logic [RawW-1:0] exp_neg_q30(input longint unsigned s);
    longint          sum;
    longint unsigned term;
    logic [69:0]     prod;
    sum  = longint'(OneQ30);
    term = OneQ30;
    for (int n = 1; n <= ExpTerms; n++) begin
      prod = 70'((term * s) >> 30) * 70'(RecipQ35[n]);
      term = 64'(prod >> 35);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return RawW'((longint'(unsigned'(sum)) + 8192) >> 14);
  endfunction

  function automatic exp_table_t build_exp_table();
    exp_table_t t;
    for (int k = 0; k < ExpDepth; k++) begin
      t[k] = exp_neg_q30((longint'(unsigned'(k)) * Ln2Q30) / ExpDepth);
    end
    return t;
  endfunction

  localparam exp_table_t ExpTable = build_exp_table();

endpackage

### src/smcw_div.sv
// Restoring divider, one quotient bit per cycle, for the weight normalization.
// Depends on smcw_pkg. The quotient is known to fit in QuoW bits.
module smcw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smcw_pkg::NumW-1:0]  num_i,
  input  logic [smcw_pkg::SumW-1:0]  den_i,
  output logic                       done_o,
  output logic [smcw_pkg::QuoW-1:0]  quo_o
);
  import smcw_pkg::*;

  logic [SumW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]    sh_q, sh_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d, done_q, done_d;
  logic [SumW:0]      trial;
  logic               ge;

  assign trial = {rem_q, sh_q[QuoW-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = SumW'(num_i[NumW-1:QuoW]);
      sh_d  = num_i[QuoW-1:0];
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? SumW'(trial - {1'b0, den_i}) : SumW'(trial);
      sh_d  = {sh_q[QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(QuoW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

### src/smcw_datapath.sv
// Datapath: child stores, run sums, exponent and weight arithmetic, node value.
// Depends on smcw_pkg and smcw_div; steered by smcw_ctrl through cmd_t.
module smcw_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        sharpness_i,
  input  smcw_pkg::item_t   item_i,
  input  smcw_pkg::cmd_t    cmd_i,
  output smcw_pkg::stat_t   stat_o,
  output smcw_pkg::result_t res_o
);
  import smcw_pkg::*;

  logic signed [15:0] vmem [MaxChildren];
  logic [RawW-1:0]    rmem [MaxChildren];

  logic [CntW-1:0]    count_q;
  logic [PsW-1:0]     ps_q;
  logic signed [15:0] best_q, own_q, vrd_q, nv_q;
  logic               ovf_q;
  logic [IdxW-1:0]    idx_q;
  logic signed [AccW-1:0] acc_q;
  logic [SumW-1:0]    sum_q;
  logic [23:0]        m_q;
  logic [40:0]        p_q;
  logic [RawW-1:0]    rrd_q;
  logic [NumW-2:0]    prod_q;
  logic [15:0]        w_q;

  logic               room, idx_last;
  logic signed [16:0] diff;
  logic [10:0]        shn;
  logic [RawW-1:0]    e;
  logic signed [25:0] one_minus;
  logic signed [41:0] init_prod;
  logic [NumW-1:0]    num;
  logic               div_done;
  logic [QuoW-1:0]    quo;
  logic [15:0]        wsat;
  logic signed [32:0] wq;
  logic [AccW-1:0]    mag, rr;
  logic signed [15:0] nv;

  assign room     = count_q < CntW'(MaxChildren);
  assign idx_last = (CntW'(idx_q) + 1'b1) == count_q;
  assign diff     = {best_q[15], best_q} - {vrd_q[15], vrd_q};
  assign shn      = p_q[40:30];
  assign e        = (shn > 11'd16) ? '0 : (ExpTable[p_q[29 -: ExpAw]] >> shn[4:0]);
  assign one_minus = 26'sd32768 - $signed({2'b00, ps_q});
  assign init_prod = one_minus * own_q;
  assign num      = {1'b0, prod_q} + NumW'(sum_q >> 1);

  smcw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (num),
    .den_i  (sum_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    if (sum_q == '0) begin
      wsat = '0;
    end else if (quo > QuoW'(16'hFFFF)) begin
      wsat = 16'hFFFF;
    end else begin
      wsat = quo[15:0];
    end
  end

  assign wq  = $signed({1'b0, wsat}) * vrd_q;
  assign mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign rr  = (mag + AccW'(16384)) >> 15;
  always_comb begin
    nv = (rr > AccW'(16384)) ? 16'sd16384 : $signed(rr[15:0]);
    if (acc_q[AccW-1]) begin
      nv = -nv;
    end
  end

  // run control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ps_q    <= '0;
      best_q  <= BestReset;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          count_q <= count_q + 1'b1;
          ps_q    <= ps_q + PsW'(item_i.child_prior);
          if (item_i.child_q > best_q) begin
            best_q <= item_i.child_q;
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.ex) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.out) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
        if (idx_last) begin
          count_q <= '0;
          ps_q    <= '0;
          best_q  <= BestReset;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      vmem[count_q[IdxW-1:0]] <= item_i.child_q;
    end
    if (cmd_i.load) begin
      own_q <= item_i.own_value;
    end
    if (cmd_i.p1_rd || cmd_i.p2_rd) begin
      vrd_q <= vmem[idx_q];
    end
    if (cmd_i.p2_rd) begin
      rrd_q <= rmem[idx_q];
    end
    if (cmd_i.ex) begin
      rmem[idx_q] <= e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      acc_q <= AccW'(init_prod);
      sum_q <= '0;
    end
    if (cmd_i.m1) begin
      m_q <= 24'(sharpness_i) * 24'(diff[15:0]);
    end
    if (cmd_i.m2) begin
      p_q <= 41'(m_q) * 41'(Log2eQ16);
    end
    if (cmd_i.ex) begin
      sum_q <= sum_q + SumW'(e);
    end
    if (cmd_i.p2_mul) begin
      prod_q <= 41'(rrd_q) * 41'(ps_q);
    end
    if (cmd_i.acc) begin
      w_q   <= wsat;
      acc_q <= acc_q - AccW'(wq);
    end
    if (cmd_i.nv) begin
      nv_q <= nv;
    end
  end

  assign stat_o.idx_last = idx_last;
  assign stat_o.div_done = div_done;

  assign res_o.child_index  = 6'(idx_q);
  assign res_o.child_weight = w_q;
  assign res_o.node_value   = idx_last ? nv_q : 16'sd0;
  assign res_o.last_result  = idx_last;
  assign res_o.overflow     = ovf_q;

endmodule

### src/smcw_ctrl.sv
// Controller: sequences loading, the exponent pass and the weight pass.
// Depends on smcw_pkg; drives smcw_datapath through cmd_t.
module smcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            last_i,
  input  smcw_pkg::stat_t stat_i,
  output smcw_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import smcw_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_INIT  = 13'b0000000000010,
    ST_P1RD  = 13'b0000000000100,
    ST_P1M1  = 13'b0000000001000,
    ST_P1M2  = 13'b0000000010000,
    ST_P1EX  = 13'b0000000100000,
    ST_P2RD  = 13'b0000001000000,
    ST_P2MUL = 13'b0000010000000,
    ST_P2GO  = 13'b0000100000000,
    ST_P2DIV = 13'b0001000000000,
    ST_P2ACC = 13'b0010000000000,
    ST_P2NV  = 13'b0100000000000,
    ST_P2OUT = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i && last_i) state_d = ST_INIT;
      ST_INIT:  state_d = ST_P1RD;
      ST_P1RD:  state_d = ST_P1M1;
      ST_P1M1:  state_d = ST_P1M2;
      ST_P1M2:  state_d = ST_P1EX;
      ST_P1EX:  state_d = stat_i.idx_last ? ST_P2RD : ST_P1RD;
      ST_P2RD:  state_d = ST_P2MUL;
      ST_P2MUL: state_d = ST_P2GO;
      ST_P2GO:  state_d = ST_P2DIV;
      ST_P2DIV: if (stat_i.div_done) state_d = ST_P2ACC;
      ST_P2ACC: state_d = stat_i.idx_last ? ST_P2NV : ST_P2OUT;
      ST_P2NV:  state_d = ST_P2OUT;
      ST_P2OUT: state_d = stat_i.idx_last ? ST_IDLE : ST_P2RD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = state_q != ST_IDLE;
  assign cmd_o.load    = (state_q == ST_IDLE) && start_i;
  assign cmd_o.init    = state_q == ST_INIT;
  assign cmd_o.p1_rd   = state_q == ST_P1RD;
  assign cmd_o.m1      = state_q == ST_P1M1;
  assign cmd_o.m2      = state_q == ST_P1M2;
  assign cmd_o.ex      = state_q == ST_P1EX;
  assign cmd_o.p2_rd   = state_q == ST_P2RD;
  assign cmd_o.p2_mul  = state_q == ST_P2MUL;
  assign cmd_o.div_go  = state_q == ST_P2GO;
  assign cmd_o.acc     = state_q == ST_P2ACC;
  assign cmd_o.nv      = state_q == ST_P2NV;
  assign cmd_o.out     = state_q == ST_P2OUT;

endmodule

### src/softmax_child_weighting_core.sv
// Top level of the softmax child weighting core: configuration register and APB port.
// Depends on smcw_pkg, smcw_ctrl and smcw_datapath.
//
// Usage: drive item_i and raise start while busy is low; the word is taken at that edge.
// Each child is taken at that edge and busy stays low, so children may follow back to back.
// The word with last_child set closes the node: busy rises and the block walks the
// stored children twice. Per child the exponent pass does a store read, two
// multiplies and a table lookup. Per child the weight pass does a read, a multiply,
// the divider launch, the one-bit-per-cycle divider (24 steps and its done flag),
// accumulate and output; the last child adds a step for node value rounding.
// Results come in load order, each for one cycle with res_valid_o high; the receiver
// cannot stall. The final result carries last_result and node_value, and busy falls on the
// next cycle. After the last word busy stays high through the setup state, both
// passes and the rounding step.
// Children past capacity are dropped and flag overflow on every result of the node.
// Reset clears the run state and sets sharpness to 35; the stores need no clearing.
// sharpness sits at APB byte address 0; pready is always high.
module softmax_child_weighting_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smcw_pkg::item_t   item_i,
  output logic              res_valid_o,
  output smcw_pkg::result_t res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import smcw_pkg::*;

  logic [7:0] sharp_q;
  cmd_t       cmd;
  stat_t      stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sharp_q <= SharpReset;
    end else if (psel && penable && pwrite && (paddr[2] == AddrSharp[2])) begin
      sharp_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrSharp[2]) ? {24'd0, sharp_q} : 32'd0;

  smcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .last_i (item_i.last_child),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  smcw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sharpness_i(sharp_q),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o)
  );

  assign res_valid_o = cmd.out;

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result word outside a busy run");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |=> !busy) else $error("run did not end");
  a_mid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !item_i.last_child |=> !busy) else $error("busy after plain load");
  a_last_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.last_child |=> busy && !res_valid_o)
    else $error("last word did not start a run");

endmodule
